// ===== rtl/core/sha_pkg.sv =====
// shared types, round constants and helper functions of the sha-256 core
// used by sha_compress, sha_ctrl and sha256_hash_core; no dependencies
package sha_pkg;

    // round constants of the compression function
    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // initial hash value
    localparam logic [31:0] HASH_IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // compression engine phases
    typedef enum logic [1:0] {
        CP_IDLE,
        CP_LOAD,
        CP_ROUND,
        CP_ADD
    } t_cphase;

    // message sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_COMP,
        ST_ORD,
        ST_OLAT,
        ST_OSEND
    } t_state;

    // block word write from the sequencer
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } t_wreq;

    // control from the sequencer to the engine
    typedef struct packed {
        logic       start;
        logic       hclr;
        logic [2:0] haddr;
    } t_creq;

    // status and hash read data from the engine
    typedef struct packed {
        logic        done;
        logic [31:0] hash_rd;
    } t_cresp;

    function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== rtl/core/sha_compress.sv =====
// compression engine: block word memory, hash memory and one round per cycle
// depends on sha_pkg
module sha_compress (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sha_pkg::t_wreq i_wreq,
    input  sha_pkg::t_creq i_creq,
    output sha_pkg::t_cresp o_cresp
);

    sha_pkg::t_cphase r_phase, n_phase;
    logic [5:0]  r_cnt, n_cnt;

    // working variables a..h and the last seven schedule words
    logic [31:0] r_v [0:7];
    logic [31:0] r_hist [0:6];

    // block word memory, two read ports
    logic [31:0] r_wmem [0:15];
    logic [31:0] r_rda, r_rdb;
    logic [3:0]  ra, rb;
    logic        w_en;
    logic [3:0]  w_addr;
    logic [31:0] w_data;

    // hash memory, one read port, valid bits stand for the initial value
    logic [31:0] r_hmem [0:7];
    logic [7:0]  r_hvalid;
    logic [31:0] r_hq;
    logic        r_hq_ok;
    logic [2:0]  r_hq_addr;
    logic [2:0]  h_ra;
    logic        hw_en;
    logic [2:0]  hw_addr;
    logic [31:0] hw_data;
    logic [31:0] hash_rd;

    logic [31:0] w_sched;
    logic [31:0] t1, t2;
    logic        done;

    assign hash_rd = r_hq_ok ? r_hq : sha_pkg::HASH_IV[r_hq_addr];

    // schedule word: from memory for the first sixteen rounds, then expanded
    always_comb begin
        if (r_cnt[5:4] == 2'd0) begin
            w_sched = r_rda;
        end else begin
            w_sched = sha_pkg::ssig1(r_hist[1]) + r_hist[6]
                    + sha_pkg::ssig0(r_rdb) + r_rda;
        end
    end

    // round function
    always_comb begin
        t1 = r_v[7] + sha_pkg::bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + sha_pkg::ROUND_K[r_cnt] + w_sched;
        t2 = sha_pkg::bsig0(r_v[0])
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sha_pkg::CP_IDLE;
            r_cnt   <= 6'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // next phase, memory addresses and write enables
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        ra      = 4'd0;
        rb      = 4'd0;
        h_ra    = i_creq.haddr;
        hw_en   = 1'b0;
        hw_addr = r_cnt[2:0] - 3'd1;
        hw_data = hash_rd + r_v[0];
        done    = 1'b0;
        w_en    = i_wreq.en;
        w_addr  = i_wreq.addr;
        w_data  = i_wreq.data;
        unique case (r_phase)
            sha_pkg::CP_IDLE: begin
                if (i_creq.start) begin
                    n_phase = sha_pkg::CP_LOAD;
                    n_cnt   = 6'd0;
                end
            end
            sha_pkg::CP_LOAD: begin
                h_ra  = r_cnt[2:0];
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd8) begin
                    n_phase = sha_pkg::CP_ROUND;
                    n_cnt   = 6'd0;
                    ra      = 4'd0;
                    rb      = 4'd1;
                end
            end
            sha_pkg::CP_ROUND: begin
                // prefetch the words of the next round
                ra     = r_cnt[3:0] + 4'd1;
                rb     = r_cnt[3:0] + 4'd2;
                w_en   = (r_cnt[5:4] != 2'd0);
                w_addr = r_cnt[3:0];
                w_data = w_sched;
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_phase = sha_pkg::CP_ADD;
                    n_cnt   = 6'd0;
                end
            end
            sha_pkg::CP_ADD: begin
                h_ra  = r_cnt[2:0];
                hw_en = (r_cnt != 6'd0);
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd8) begin
                    n_phase = sha_pkg::CP_IDLE;
                    n_cnt   = 6'd0;
                    done    = 1'b1;
                end
            end
        endcase
    end

    // block word memory
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wmem[w_addr] <= w_data;
        end
        r_rda <= r_wmem[ra];
        r_rdb <= r_wmem[rb];
    end

    // hash memory
    always_ff @(posedge i_clk) begin
        if (hw_en) begin
            r_hmem[hw_addr] <= hw_data;
        end
        r_hq      <= r_hmem[h_ra];
        r_hq_ok   <= r_hvalid[h_ra];
        r_hq_addr <= h_ra;
    end

    // hash valid bits, cleared after each digest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_creq.hclr) begin
            r_hvalid <= 8'd0;
        end else if (hw_en) begin
            r_hvalid[hw_addr] <= 1'b1;
        end
    end

    // working variables and schedule history
    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            sha_pkg::CP_LOAD: begin
                if (r_cnt != 6'd0) begin
                    for (int i = 0; i < 7; i++) begin
                        r_v[i] <= r_v[i+1];
                    end
                    r_v[7] <= hash_rd;
                end
            end
            sha_pkg::CP_ROUND: begin
                r_v[0] <= t1 + t2;
                r_v[1] <= r_v[0];
                r_v[2] <= r_v[1];
                r_v[3] <= r_v[2];
                r_v[4] <= r_v[3] + t1;
                r_v[5] <= r_v[4];
                r_v[6] <= r_v[5];
                r_v[7] <= r_v[6];
                r_hist[0] <= w_sched;
                for (int i = 1; i < 7; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
            end
            sha_pkg::CP_ADD: begin
                if (r_cnt != 6'd0) begin
                    for (int i = 0; i < 7; i++) begin
                        r_v[i] <= r_v[i+1];
                    end
                end
            end
            sha_pkg::CP_IDLE: begin
            end
        endcase
    end

    assign o_cresp.done    = done;
    assign o_cresp.hash_rd = hash_rd;

endmodule

// ===== rtl/core/sha_ctrl.sv =====
// message sequencer: byte packing, padding, length field and digest output
// depends on sha_pkg; drives the sha_compress engine
module sha_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [39:0]     i_s_tdata,   // [31:0] message_word, [34:32] valid_bytes
    input  logic            i_s_tlast,   // last_word
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [39:0]     o_m_tdata,   // [31:0] digest_word, [34:32] digest_index
    output logic            o_m_tlast,   // digest_done
    output sha_pkg::t_wreq  o_wreq,
    output sha_pkg::t_creq  o_creq,
    input  sha_pkg::t_cresp i_cresp
);

    sha_pkg::t_state r_state, n_state;
    sha_pkg::t_state r_ret, n_ret;
    logic [5:0]  r_fill, n_fill;
    logic [31:0] r_part, n_part;
    logic [63:0] r_len, n_len;
    logic [3:0]  r_widx, n_widx;
    logic        r_wrap, n_wrap;
    logic [2:0]  r_oidx, n_oidx;
    logic [31:0] r_odata, n_odata;
    logic        r_ovalid, n_ovalid;

    logic        accept;
    logic [2:0]  cnt;
    logic [1:0]  lane;
    logic [31:0] masked;
    logic [63:0] ext;
    logic [63:0] merged;
    logic [2:0]  total;
    logic [31:0] pad_word;

    assign o_s_tready = (r_state == sha_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // merge the new bytes behind the partial word
    always_comb begin
        cnt      = (i_s_tdata[34:32] > 3'd4) ? 3'd4 : i_s_tdata[34:32];
        lane     = r_fill[1:0];
        masked   = i_s_tdata[31:0] & ~(32'hffff_ffff >> {cnt, 3'b000});
        ext      = {masked, 32'h0} >> {lane, 3'b000};
        merged   = {r_part, 32'h0} | ext;
        total    = {1'b0, lane} + cnt;
        pad_word = r_part | (32'h8000_0000 >> {lane, 3'b000});
    end

    // state and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha_pkg::ST_IDLE;
            r_ret    <= sha_pkg::ST_IDLE;
            r_fill   <= 6'd0;
            r_part   <= 32'd0;
            r_len    <= 64'd0;
            r_widx   <= 4'd0;
            r_wrap   <= 1'b0;
            r_oidx   <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_fill   <= n_fill;
            r_part   <= n_part;
            r_len    <= n_len;
            r_widx   <= n_widx;
            r_wrap   <= n_wrap;
            r_oidx   <= n_oidx;
            r_ovalid <= n_ovalid;
        end
        r_odata <= n_odata;
    end

    // next state and block writes
    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_fill       = r_fill;
        n_part       = r_part;
        n_len        = r_len;
        n_widx       = r_widx;
        n_wrap       = r_wrap;
        n_oidx       = r_oidx;
        n_odata      = r_odata;
        n_ovalid     = r_ovalid;
        o_wreq.en    = 1'b0;
        o_wreq.addr  = r_widx;
        o_wreq.data  = 32'd0;
        o_creq.start = 1'b0;
        o_creq.hclr  = 1'b0;
        o_creq.haddr = r_oidx;
        unique case (r_state)
            sha_pkg::ST_IDLE: begin
                if (accept) begin
                    n_fill = r_fill + {3'b000, cnt};
                    n_len  = r_len + {58'd0, cnt, 3'b000};
                    if (total[2]) begin
                        o_wreq.en   = 1'b1;
                        o_wreq.addr = r_fill[5:2];
                        o_wreq.data = merged[63:32];
                        n_part      = merged[31:0];
                    end else begin
                        n_part = merged[63:32];
                    end
                    if (total[2] && (r_fill[5:2] == 4'd15)) begin
                        // block full: compress, then pad or wait for more
                        o_creq.start = 1'b1;
                        n_state      = sha_pkg::ST_COMP;
                        n_ret        = i_s_tlast ? sha_pkg::ST_PAD : sha_pkg::ST_IDLE;
                    end else if (i_s_tlast) begin
                        n_state = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                // 0x80 marker behind the last message byte
                o_wreq.en   = 1'b1;
                o_wreq.addr = r_fill[5:2];
                o_wreq.data = pad_word;
                n_widx      = r_fill[5:2] + 4'd1;
                n_wrap      = (r_fill[5:2] == 4'd14);
                if (r_fill[5:2] == 4'd15) begin
                    o_creq.start = 1'b1;
                    n_ret        = sha_pkg::ST_ZERO;
                    n_state      = sha_pkg::ST_COMP;
                end else begin
                    n_state = sha_pkg::ST_ZERO;
                end
            end
            sha_pkg::ST_ZERO: begin
                // zero fill up to the length field, through an extra block if needed
                if ((r_widx == 4'd14) && !r_wrap) begin
                    n_state = sha_pkg::ST_LEN;
                end else begin
                    o_wreq.en   = 1'b1;
                    o_wreq.data = 32'd0;
                    n_widx      = r_widx + 4'd1;
                    if (r_widx == 4'd15) begin
                        n_wrap       = 1'b0;
                        o_creq.start = 1'b1;
                        n_ret        = sha_pkg::ST_ZERO;
                        n_state      = sha_pkg::ST_COMP;
                    end
                end
            end
            sha_pkg::ST_LEN: begin
                o_wreq.en   = 1'b1;
                o_wreq.data = (r_widx == 4'd14) ? r_len[63:32] : r_len[31:0];
                n_widx      = r_widx + 4'd1;
                if (r_widx == 4'd15) begin
                    o_creq.start = 1'b1;
                    n_ret        = sha_pkg::ST_ORD;
                    n_state      = sha_pkg::ST_COMP;
                end
            end
            sha_pkg::ST_COMP: begin
                if (i_cresp.done) begin
                    n_state = r_ret;
                end
            end
            sha_pkg::ST_ORD: begin
                // hash read issued at r_oidx
                n_state = sha_pkg::ST_OLAT;
            end
            sha_pkg::ST_OLAT: begin
                n_odata  = i_cresp.hash_rd;
                n_ovalid = 1'b1;
                n_state  = sha_pkg::ST_OSEND;
            end
            sha_pkg::ST_OSEND: begin
                if (i_m_tready) begin
                    n_ovalid = 1'b0;
                    if (r_oidx == 3'd7) begin
                        // digest done: back to the initial state
                        o_creq.hclr = 1'b1;
                        n_oidx      = 3'd0;
                        n_fill      = 6'd0;
                        n_part      = 32'd0;
                        n_len       = 64'd0;
                        n_state     = sha_pkg::ST_IDLE;
                    end else begin
                        n_oidx  = r_oidx + 3'd1;
                        n_state = sha_pkg::ST_ORD;
                    end
                end
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_oidx, r_odata};
    assign o_m_tlast  = (r_oidx == 3'd7);

endmodule

// ===== rtl/core/sha256_hash_core.sv =====
// sha-256 hash core top level: sequencer plus compression engine
// depends on sha_pkg, sha_ctrl and sha_compress
//
// SHA-256 over a byte message given as 32-bit big-endian words, each request
// carrying 0 to 4 valid leading bytes (counts above 4 count as 4). Bytes are
// packed back to back, so short words may appear anywhere in the message.
// When a request completes a 64-byte block the engine loads the hash words
// from the hash memory, runs 64 rounds at one per cycle over the block word
// memory and adds back and writes, during which no request is taken. After
// the request marked last the core writes the padding and 64-bit bit length
// one word per cycle, pausing while a block compresses, compresses one or
// two more blocks and sends the eight digest words, index 0 first, each
// read, latched and held until taken; tlast marks index 7. The core then
// returns to its initial state by itself. No memory clearing pass follows
// reset.
module sha256_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [31:0] message_word, [34:32] valid_bytes, rest zero
    input  logic        i_s_tlast,   // last_word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] digest_word, [34:32] digest_index, rest zero
    output logic        o_m_tlast    // digest_done
);

    sha_pkg::t_wreq  wreq;
    sha_pkg::t_creq  creq;
    sha_pkg::t_cresp cresp;

    // message packing, padding and output
    sha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_wreq     (wreq),
        .o_creq     (creq),
        .i_cresp    (cresp)
    );

    // compression engine with block and hash memories
    sha_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wreq  (wreq),
        .i_creq  (creq),
        .o_cresp (cresp)
    );

endmodule
